// ===== design/mtad_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mtad_pkg
// shared types and constants of the minimum total absolute distance unit
// ----------------------------------------------------------------------------
package mtad_pkg;

    localparam int POSITION_W = 16;
    localparam int TOTAL_W    = 26;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef struct packed {
        logic start;
        logic ack;
    } mtad_ctrl_t;

endpackage
`default_nettype wire

// ===== design/mtad_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mtad_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module mtad_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== design/mtad_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mtad_engine
// median select by bitwise counting passes, then one pass summing distances
// ----------------------------------------------------------------------------
module mtad_engine
    import mtad_pkg::*;
#(
    parameter int POS_BITS  = 16,
    parameter int MAX_ITEMS = 1024,
    localparam int AW       = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1,
    localparam int CNT_W    = $clog2(MAX_ITEMS + 1)
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire mtad_ctrl_t          ctrl,
    input  wire logic [CNT_W-1:0]    count,
    output logic      [AW-1:0]       raddr,
    input  wire logic [POS_BITS-1:0] rdata,
    output logic                     done,
    output logic      [TOTAL_W-1:0]  total
);

    localparam int SUM_W  = POS_BITS + CNT_W;
    localparam int WIDE_W = (SUM_W > TOTAL_W) ? SUM_W : TOTAL_W;
    localparam logic [POS_BITS-1:0] TOP_BIT = POS_BITS'(1) << (POS_BITS - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RUN  = 3'd1;
    localparam logic [2:0] S_TAIL = 3'd2;
    localparam logic [2:0] S_NEXT = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic                rd_valid_reg, rd_valid_next;
    logic                sum_phase_reg, sum_phase_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [AW-1:0]       last_idx_reg, last_idx_next;
    logic [CNT_W-1:0]    k_reg, k_next;
    logic [POS_BITS-1:0] prefix_reg, prefix_next;
    logic [POS_BITS-1:0] mask_reg, mask_next;
    logic [POS_BITS-1:0] bit_reg, bit_next;
    logic [SUM_W-1:0]    acc_reg, acc_next;

    logic                match;
    logic [POS_BITS-1:0] gap;
    logic [SUM_W-1:0]    addend;
    logic [SUM_W-1:0]    acc_sum;
    logic [SUM_W-1:0]    k_ext;
    logic                take_one;
    logic [CNT_W-1:0]    n_minus;
    logic [WIDE_W-1:0]   acc_wide;

    // shared accumulator: ones for counting passes, distances for the sum pass
    assign match    = (((rdata ^ prefix_reg) & mask_reg) == '0);
    assign gap      = (rdata >= prefix_reg) ? (rdata - prefix_reg) : (prefix_reg - rdata);
    assign addend   = sum_phase_reg ? SUM_W'(gap) : SUM_W'(match);
    assign acc_sum  = acc_reg + addend;
    assign k_ext    = SUM_W'(k_reg);
    assign take_one = (k_ext >= acc_reg);
    assign n_minus  = count - CNT_W'(1);
    assign acc_wide = WIDE_W'(acc_reg);

    assign raddr = idx_reg;
    assign done  = (state_reg == S_DONE);
    assign total = (acc_wide > WIDE_W'(TOTAL_MAX)) ? TOTAL_MAX : acc_wide[TOTAL_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        rd_valid_next  = 1'b0;
        sum_phase_next = sum_phase_reg;
        idx_next       = idx_reg;
        last_idx_next  = last_idx_reg;
        k_next         = k_reg;
        prefix_next    = prefix_reg;
        mask_next      = mask_reg;
        bit_next       = bit_reg;
        acc_next       = acc_reg;

        if (rd_valid_reg)
        begin
            acc_next = acc_sum;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (ctrl.start)
                begin
                    last_idx_next  = AW'(n_minus);
                    k_next         = n_minus >> 1;
                    prefix_next    = '0;
                    mask_next      = TOP_BIT;
                    bit_next       = TOP_BIT;
                    acc_next       = '0;
                    idx_next       = '0;
                    sum_phase_next = 1'b0;
                    state_next     = S_RUN;
                end
            end
            S_RUN:
            begin
                rd_valid_next = 1'b1;
                idx_next      = idx_reg + AW'(1);
                if (idx_reg == last_idx_reg)
                begin
                    state_next = S_TAIL;
                end
            end
            S_TAIL:
            begin
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                if (sum_phase_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    // lower median bit is one when too few lie below it
                    if (take_one)
                    begin
                        prefix_next = prefix_reg | bit_reg;
                        k_next      = CNT_W'(k_ext - acc_reg);
                    end
                    if (bit_reg[0])
                    begin
                        sum_phase_next = 1'b1;
                    end
                    else
                    begin
                        mask_next = mask_reg | (bit_reg >> 1);
                        bit_next  = bit_reg >> 1;
                    end
                    acc_next   = '0;
                    idx_next   = '0;
                    state_next = S_RUN;
                end
            end
            S_DONE:
            begin
                if (ctrl.ack)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_valid_reg  <= 1'b0;
            sum_phase_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_valid_reg  <= rd_valid_next;
            sum_phase_reg <= sum_phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        last_idx_reg <= last_idx_next;
        k_reg        <= k_next;
        prefix_reg   <= prefix_next;
        mask_reg     <= mask_next;
        bit_reg      <= bit_next;
        acc_reg      <= acc_next;
    end

endmodule
`default_nettype wire

// ===== design/min_total_abs_distance_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// min_total_abs_distance_unit
// least total absolute distance of a set of positions to an integer point
// ----------------------------------------------------------------------------
// positions arrive on the input channel, one per transfer, and are stored at
// one per cycle while in_ready is high. the transfer with last set closes
// the set (and is a member of it). up to MAX_ITEMS positions are kept; more
// are dropped and the overflow bit of the result is set.
// after the closing transfer the engine runs POS_BITS counting passes over the
// store to pick the lower median bit by bit, then one pass that sums the
// distances to it. each pass reads the store through its single read port,
// one entry a cycle. in_ready is low from the closing transfer until the
// result moves into the output register and high otherwise.
// the result sits in an output register; the next set may load while it waits
// for out_ready. a finished result of that next set waits inside the engine
// until the output register is free. the sum saturates at 26 bits.
// reset empties the set and the output register; the store needs no clearing.
// ----------------------------------------------------------------------------
module min_total_abs_distance_unit
    import mtad_pkg::*;
#(
    parameter int MAX_ITEMS = 1024,
    parameter int POS_BITS  = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [POSITION_W-1:0] position,
    input  wire logic                  last,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic      [TOTAL_W-1:0]    min_total,
    output logic                       overflow
);

    localparam int AW    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int EXT_W = (POS_BITS > POSITION_W) ? POS_BITS : POSITION_W;

    logic [CNT_W-1:0]   count_reg, count_next;
    logic               drop_reg, drop_next;
    logic               busy_reg, busy_next;
    logic               ovf_pend_reg, ovf_pend_next;
    logic               out_valid_reg, out_valid_next;
    logic [TOTAL_W-1:0] min_total_reg, min_total_next;
    logic               overflow_reg, overflow_next;

    logic                in_fire;
    logic                has_room;
    logic                we;
    logic [CNT_W-1:0]    count_inc;
    logic                drop_upd;
    logic [EXT_W-1:0]    pos_ext;
    logic [POS_BITS-1:0] wdata;
    logic [AW-1:0]       raddr;
    logic [POS_BITS-1:0] rdata;
    logic                eng_done;
    logic [TOTAL_W-1:0]  eng_total;
    logic                move;
    mtad_ctrl_t          ctrl;

    assign in_ready  = !busy_reg;
    assign in_fire   = in_valid && in_ready;
    assign has_room  = (count_reg < CNT_W'(MAX_ITEMS));
    assign we        = in_fire && has_room;
    assign count_inc = we ? (count_reg + CNT_W'(1)) : count_reg;
    assign drop_upd  = drop_reg || (in_fire && !has_room);
    assign pos_ext   = EXT_W'(position);
    assign wdata     = pos_ext[POS_BITS-1:0];
    assign move      = eng_done && (!out_valid_reg || out_ready);

    assign ctrl.start = in_fire && last;
    assign ctrl.ack   = move;

    assign out_valid = out_valid_reg;
    assign min_total = min_total_reg;
    assign overflow  = overflow_reg;

    mtad_ram #(
        .WIDTH (POS_BITS),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (count_reg[AW-1:0]),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    mtad_engine #(
        .POS_BITS  (POS_BITS),
        .MAX_ITEMS (MAX_ITEMS)
    ) u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .count (count_inc),
        .raddr (raddr),
        .rdata (rdata),
        .done  (eng_done),
        .total (eng_total)
    );

    always_comb
    begin
        count_next     = count_inc;
        drop_next      = drop_upd;
        busy_next      = busy_reg;
        ovf_pend_next  = ovf_pend_reg;
        out_valid_next = out_valid_reg;
        min_total_next = min_total_reg;
        overflow_next  = overflow_reg;

        // closing transfer hands the set to the engine
        if (ctrl.start)
        begin
            count_next    = '0;
            drop_next     = 1'b0;
            ovf_pend_next = drop_upd;
            busy_next     = 1'b1;
        end

        if (move)
        begin
            out_valid_next = 1'b1;
            min_total_next = eng_total;
            overflow_next  = ovf_pend_reg;
            busy_next      = 1'b0;
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            drop_reg      <= 1'b0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            drop_reg      <= drop_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ovf_pend_reg  <= ovf_pend_next;
        min_total_reg <= min_total_next;
        overflow_reg  <= overflow_next;
    end

endmodule
`default_nettype wire

// ===== design/mtad_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mtad_checker
// port level checks of the minimum total absolute distance unit
// ----------------------------------------------------------------------------
module mtad_checker
    import mtad_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_ready,
    input wire logic [POSITION_W-1:0] position,
    input wire logic                  last,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire logic [TOTAL_W-1:0]    min_total,
    input wire logic                  overflow
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(min_total) && $stable(overflow))
        else $error("result changed while stalled");

    // closing transfer makes the block busy
    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last |=> !in_ready)
        else $error("input still ready after closing transfer");

    // a new result only comes out of a busy period
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result without a closed set");

    // a busy period only ends with a result waiting at the output
    a_ready_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && !$past(in_ready) |-> out_valid)
        else $error("busy period ended without a result");

endmodule

bind min_total_abs_distance_unit mtad_checker u_checker (.*);
`default_nettype wire
